>>> rtl/core/osm_pkg.sv
// ----------------------------------------------------------------------------
// osm_pkg
// shared types and codes for the order statistic multiset
// ----------------------------------------------------------------------------
package osm_pkg;

    localparam int KEY_W = 32;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_RANK   = 3'd2;
    localparam logic [2:0] OP_SELECT = 3'd3;
    localparam logic [2:0] OP_PRED   = 3'd4;
    localparam logic [2:0] OP_SUCC   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [KEY_W-1:0] NONE_HI = 32'h7f7f7f7f;
    localparam logic [KEY_W-1:0] NONE_LO = 32'h80808081;

    typedef struct packed {
        logic vld;
        logic lt;
        logic le;
        logic eq;
        logic sel;
    } cell_flags_t;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } cell_ctl_t;

endpackage

>>> rtl/core/order_statistic_multiset.sv
// ----------------------------------------------------------------------------
// order_statistic_multiset
// ordered multiset of signed keys kept in a sorted row of cells
//
//   channel  direction  handshake             payload
//   request  in         req_valid/req_ready   opcode, key
//   response out        rsp_valid/rsp_ready   answer, status
//
// in the compare step the cells compare against the key; in the reduce step the
// flags are folded into the answer while the row shifts for insert/delete
// a new request is taken in the cycle the previous one finishes
// the response sits in an output register; a held response stalls only
// the reduce step of the next request
// reset empties the store; the key row itself is not cleared
// ----------------------------------------------------------------------------
module order_statistic_multiset
    import osm_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [2:0]              opcode,
    input  logic signed [KEY_W-1:0] key,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic signed [KEY_W-1:0] answer,
    output logic [1:0]              status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RED  = 2'd2;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [2:0]              op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]        occ_reg;
    logic [CNT_W-1:0]        occ_next;
    logic                    rsp_valid_reg;
    logic [KEY_W-1:0]        answer_reg;
    logic [KEY_W-1:0]        answer_next;
    logic [1:0]              status_reg;
    logic [1:0]              status_next;

    logic             accept;
    logic             finish;
    logic             full;
    cell_ctl_t        ctl;
    logic [KEY_W-1:0] keys [CAPACITY];
    cell_flags_t      flags [CAPACITY];

    logic [CNT_W-1:0] cnt_lt;
    logic             found;
    logic [KEY_W-1:0] pred_key;
    logic             succ_ok;
    logic [KEY_W-1:0] succ_key;
    logic [KEY_W-1:0] sel_key;

    assign full      = occ_reg == CNT_W'(CAPACITY);
    assign finish    = (state_reg == S_RED) && (!rsp_valid_reg || rsp_ready);
    assign req_ready = (state_reg == S_IDLE) || finish;
    assign accept    = req_valid && req_ready;

    assign ctl.cmp_en = state_reg == S_CMP;
    assign ctl.ins_en = finish && (op_reg == OP_INSERT) && !full;
    assign ctl.del_en = finish && (op_reg == OP_DELETE) && found;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_W-1:0] left_key;
        logic             left_le;
        logic [KEY_W-1:0] right_key;

        if (i == 0)
        begin : g_first
            assign left_key = '0;
            assign left_le  = 1'b1;
        end
        else
        begin : g_left
            assign left_key = keys[i-1];
            assign left_le  = flags[i-1].le;
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = keys[i];
        end
        else
        begin : g_right
            assign right_key = keys[i+1];
        end

        osm_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .req_key   (key_reg),
            .occ       (occ_reg),
            .left_key  (left_key),
            .left_le   (left_le),
            .right_key (right_key),
            .key       (keys[i]),
            .flags     (flags[i])
        );
    end

    osm_reduce #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_reduce (
        .keys     (keys),
        .flags    (flags),
        .cnt_lt   (cnt_lt),
        .found    (found),
        .pred_key (pred_key),
        .succ_ok  (succ_ok),
        .succ_key (succ_key),
        .sel_key  (sel_key)
    );

    always_comb
    begin
        answer_next = '0;
        status_next = ST_OK;
        occ_next    = occ_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (found)
                begin
                    occ_next = occ_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NONE;
                end
            end
            OP_RANK:
            begin
                answer_next = {{(KEY_W - CNT_W){1'b0}}, cnt_lt} + KEY_W'(1);
            end
            OP_SELECT:
            begin
                if (key_reg < 1)
                begin
                    answer_next = NONE_LO;
                    status_next = ST_RANGE;
                end
                else if ($unsigned(key_reg) > {{(KEY_W - CNT_W){1'b0}}, occ_reg})
                begin
                    answer_next = NONE_HI;
                    status_next = ST_RANGE;
                end
                else
                begin
                    answer_next = sel_key;
                end
            end
            OP_PRED:
            begin
                if (cnt_lt == '0)
                begin
                    answer_next = NONE_LO;
                    status_next = ST_NONE;
                end
                else
                begin
                    answer_next = pred_key;
                end
            end
            OP_SUCC:
            begin
                if (succ_ok)
                begin
                    answer_next = succ_key;
                end
                else
                begin
                    answer_next = NONE_HI;
                    status_next = ST_NONE;
                end
            end
            default:
            begin
                answer_next = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_RED;
            end
            S_RED:
            begin
                if (finish)
                begin
                    state_next = accept ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                occ_reg       <= occ_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
        if (finish)
        begin
            answer_reg <= answer_next;
            status_reg <= status_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign answer    = $signed(answer_reg);
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == S_CMP)
        else $error("accepted request did not enter compare");

    a_rsp_from_red: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_RED)
        else $error("response raised outside reduce step");

    a_occ_change: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != $past(occ_reg) |-> $past(finish))
        else $error("occupancy changed outside a finished request");

    a_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.ins_en && ctl.del_en))
        else $error("insert and delete shift together");
`endif

endmodule

>>> rtl/core/osm_cell.sv
// ----------------------------------------------------------------------------
// osm_cell
// one slot of the sorted key row: compares against the request key and
// shifts left or right with its neighbors on insert and delete
// ----------------------------------------------------------------------------
module osm_cell
    import osm_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 7
)
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic signed [KEY_W-1:0] req_key,
    input  logic [CNT_W-1:0]        occ,
    input  logic [KEY_W-1:0]        left_key,
    input  logic                    left_le,
    input  logic [KEY_W-1:0]        right_key,
    output logic [KEY_W-1:0]        key,
    output cell_flags_t             flags
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    cell_flags_t      flags_reg;
    cell_flags_t      flags_next;
    logic             vld;

    assign vld = CNT_W'(CELL_IDX) < occ;

    always_comb
    begin
        flags_next.vld = vld;
        flags_next.lt  = vld && ($signed(key_reg) < req_key);
        flags_next.le  = vld && ($signed(key_reg) <= req_key);
        flags_next.eq  = vld && ($signed(key_reg) == req_key);
        flags_next.sel = $unsigned(req_key) == KEY_W'(CELL_IDX + 1);
    end

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins_en)
        begin
            if (!flags_reg.le)
            begin
                key_next = left_le ? $unsigned(req_key) : left_key;
            end
        end
        else if (ctl.del_en)
        begin
            if (!flags_reg.lt)
            begin
                key_next = right_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (ctl.cmp_en)
        begin
            flags_reg <= flags_next;
        end
    end

    assign key   = key_reg;
    assign flags = flags_reg;

endmodule

>>> rtl/core/osm_reduce.sv
// ----------------------------------------------------------------------------
// osm_reduce
// folds the cell flags into a count, a found bit and the neighbor and
// selected keys
// ----------------------------------------------------------------------------
module osm_reduce
    import osm_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
)
(
    input  logic [KEY_W-1:0] keys [CAPACITY],
    input  cell_flags_t      flags [CAPACITY],
    output logic [CNT_W-1:0] cnt_lt,
    output logic             found,
    output logic [KEY_W-1:0] pred_key,
    output logic             succ_ok,
    output logic [KEY_W-1:0] succ_key,
    output logic [KEY_W-1:0] sel_key
);

    logic [CAPACITY-1:0] lt_edge;
    logic [CAPACITY-1:0] le_edge;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_edge
        if (i == CAPACITY - 1)
        begin : g_last
            assign lt_edge[i] = flags[i].lt;
        end
        else
        begin : g_mid
            assign lt_edge[i] = flags[i].lt && !flags[i+1].lt;
        end
        if (i == 0)
        begin : g_first
            assign le_edge[i] = flags[i].vld && !flags[i].le;
        end
        else
        begin : g_rest
            assign le_edge[i] = flags[i].vld && !flags[i].le && flags[i-1].le;
        end
    end

    always_comb
    begin
        cnt_lt   = '0;
        found    = 1'b0;
        pred_key = '0;
        succ_ok  = 1'b0;
        succ_key = '0;
        sel_key  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cnt_lt   = cnt_lt | (lt_edge[i] ? CNT_W'(i + 1) : CNT_W'(0));
            found    = found | flags[i].eq;
            pred_key = pred_key | (keys[i] & {KEY_W{lt_edge[i]}});
            succ_ok  = succ_ok | le_edge[i];
            succ_key = succ_key | (keys[i] & {KEY_W{le_edge[i]}});
            sel_key  = sel_key | (keys[i] & {KEY_W{flags[i].sel && flags[i].vld}});
        end
    end

endmodule
